// File: hw/rtl/ipv4tf_pkg.sv
`default_nettype none
package ipv4tf_pkg;

  // Link limits
  localparam int unsigned MAX_LINK_PAYLOAD = 1500;
  localparam int unsigned HDR_BYTES_I      = 20;
  localparam int unsigned FRAG_PAYLOAD_I   = ((MAX_LINK_PAYLOAD - HDR_BYTES_I) / 8) * 8;

  // Field widths
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned TOTAL_W = 11;
  localparam int unsigned OFF_W   = 13;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned BASE_W  = 19;
  localparam int unsigned SUM_W   = 20;

  localparam logic [LEN_W-1:0]   HDR_BYTES     = LEN_W'(HDR_BYTES_I);
  localparam logic [LEN_W-1:0]   MAX_PAYLOAD   = 16'd65515;
  localparam logic [LEN_W:0]     MAX_LINK      = (LEN_W+1)'(MAX_LINK_PAYLOAD);
  localparam logic [LEN_W-1:0]   FRAG_PAYLOAD  = LEN_W'(FRAG_PAYLOAD_I);
  localparam logic [TOTAL_W-1:0] FRAG_TOTAL    = TOTAL_W'(FRAG_PAYLOAD_I + HDR_BYTES_I);
  localparam logic [OFF_W-1:0]   FRAG_UNITS    = OFF_W'(FRAG_PAYLOAD_I / 8);
  localparam logic [15:0]        VER_IHL_TOS   = 16'h4500;
  localparam logic [ID_W-1:0]    PACKET_ID_RST = 16'd1;
  localparam logic [7:0]         TTL_RST       = 8'd64;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_IP    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_TO_LIVE = 8'd1;

  // Queue geometry
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified request between front and back
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic              frag;
    logic [ID_W-1:0]   id;
    logic [BASE_W-1:0] base;
  } q_entry_t;

endpackage
`default_nettype wire

// File: hw/rtl/ipv4_tx_header_fragmenter_unit.sv
`default_nettype none
// IPv4 transmit header generator with fragmentation. Each request on the in_
// stream (payload length, protocol, destination) yields one result on the out_
// stream per fragment, in order of increasing offset, with tlast on the final
// fragment. The front accepts one request per cycle while its 4-entry queue has
// room; while out_tready is high the back end emits one fragment header per
// cycle and keeps a request for all of its fragments (one if the payload fits
// the link, up to 45 for the largest). Unfragmented requests therefore
// stream at one per cycle. Configuration (index 0 source address, index 1 TTL)
// is written through cfg_ and is always ready; write it only while idle.
module ipv4_tx_header_fragmenter_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ipv4tf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_data,
  // request stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [15:0] payload_length, [23:16] protocol, [55:24] dest_addr
  input  wire logic [55:0]                      in_tdata,
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [10:0] total_length, [26:11] identification, [27] more_fragments,
  // [40:28] frag_offset, [56:41] hdr_csum, [63:57] zero
  output logic [63:0]                           out_tdata,
  output logic                                  out_tlast
);
  import ipv4tf_pkg::*;

  q_entry_t           req_entry, q_data;
  logic               q_full, q_valid, q_pop, push;
  logic [TOTAL_W-1:0] o_total;
  logic [ID_W-1:0]    o_id;
  logic               o_mf;
  logic [OFF_W-1:0]   o_off;
  logic [15:0]        o_csum;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  ipv4tf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_push  (push),
    .req_len   (in_tdata[15:0]),
    .req_proto (in_tdata[23:16]),
    .req_dst   (in_tdata[55:24]),
    .req_entry (req_entry)
  );

  ipv4tf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (req_entry),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  ipv4tf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_total  (o_total),
    .out_id     (o_id),
    .out_mf     (o_mf),
    .out_off    (o_off),
    .out_csum   (o_csum),
    .out_last   (out_tlast)
  );

  // Pack result fields
  assign out_tdata = {7'b0, o_csum, o_off, o_mf, o_id, o_total};

endmodule
`default_nettype wire

// File: hw/rtl/ipv4tf_front.sv
`default_nettype none
module ipv4tf_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [ipv4tf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                       cfg_data,
  input  wire logic                              req_push,
  input  wire logic [15:0]                       req_len,
  input  wire logic [7:0]                        req_proto,
  input  wire logic [31:0]                       req_dst,
  output ipv4tf_pkg::q_entry_t                   req_entry
);
  import ipv4tf_pkg::*;

  logic [31:0]     source_ip_r;
  logic [7:0]      ttl_r;
  logic [ID_W-1:0] packet_id_r, packet_id_nxt;
  logic [LEN_W-1:0] len_sat;
  logic            frag;
  logic [ID_W-1:0] id;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_ip_r <= '0;
      ttl_r       <= TTL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SOURCE_IP:    source_ip_r <= cfg_data;
        CFG_TIME_TO_LIVE: ttl_r       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Saturate length and decide whether the request fragments
  always_comb begin
    len_sat = (req_len > MAX_PAYLOAD) ? MAX_PAYLOAD : req_len;
    frag    = (({1'b0, len_sat} + {1'b0, HDR_BYTES}) > MAX_LINK);
    id      = frag ? packet_id_r : '0;
    packet_id_nxt = (req_push && frag) ? packet_id_r + ID_W'(1) : packet_id_r;
  end

  // Advance id counter once per fragmented request
  always_ff @(posedge clk) begin
    if (!rst_n) packet_id_r <= PACKET_ID_RST;
    else        packet_id_r <= packet_id_nxt;
  end

  // Sum header words that stay fixed across all fragments
  always_comb begin
    req_entry.len  = len_sat;
    req_entry.frag = frag;
    req_entry.id   = id;
    req_entry.base = BASE_W'(VER_IHL_TOS) + BASE_W'(id) + BASE_W'({ttl_r, req_proto})
                   + BASE_W'(source_ip_r[31:16]) + BASE_W'(source_ip_r[15:0])
                   + BASE_W'(req_dst[31:16]) + BASE_W'(req_dst[15:0]);
  end

endmodule
`default_nettype wire

// File: hw/rtl/ipv4tf_queue.sv
`default_nettype none
module ipv4tf_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  ipv4tf_pkg::q_entry_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output ipv4tf_pkg::q_entry_t q_data
);
  import ipv4tf_pkg::*;

  q_entry_t            mem_r [Q_DEPTH];
  q_entry_t            q_data_r;
  logic [Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;
  logic                do_pop;

  assign full    = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = q_data_r;
  assign do_pop  = pop && q_valid;

  // Store entries, keep the head entry registered; bypass a write to the new head
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
    if (push && (wr_ptr_r == rd_ptr_nxt)) q_data_r <= push_data;
    else                                   q_data_r <= mem_r[rd_ptr_nxt];
  end

  // Track pointers and fill
  always_comb begin
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt = count_r;
    if (push && !do_pop)      count_nxt = count_r + Q_CNT_W'(1);
    else if (!push && do_pop) count_nxt = count_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/ipv4tf_back.sv
`default_nettype none
module ipv4tf_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  ipv4tf_pkg::q_entry_t               q_data,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [ipv4tf_pkg::TOTAL_W-1:0]     out_total,
  output logic [ipv4tf_pkg::ID_W-1:0]        out_id,
  output logic                               out_mf,
  output logic [ipv4tf_pkg::OFF_W-1:0]       out_off,
  output logic [15:0]                        out_csum,
  output logic                               out_last
);
  import ipv4tf_pkg::*;

  // Current request
  logic              busy_r;
  logic [LEN_W-1:0]  rem_r;
  logic [OFF_W-1:0]  off_r;
  logic [ID_W-1:0]   id_r;
  logic [BASE_W-1:0] base_r;
  logic              frag_r;

  // Output register
  logic               ovalid_r;
  logic [TOTAL_W-1:0] total_r;
  logic [ID_W-1:0]    oid_r;
  logic               mf_r;
  logic [OFF_W-1:0]   ooff_r;
  logic [15:0]        csum_r;
  logic               last_r;

  logic               adv, more, load;
  logic [LEN_W-1:0]   rem_plus;
  logic [TOTAL_W-1:0] tot;
  logic [15:0]        flags_off;
  logic [SUM_W-1:0]   sum;
  logic [16:0]        fold1;
  logic [16:0]        fold2;

  // Build one fragment header per cycle while the output register can advance
  always_comb begin
    adv       = busy_r && (!ovalid_r || out_tready);
    more      = frag_r && (rem_r > FRAG_PAYLOAD);
    rem_plus  = rem_r + HDR_BYTES;
    tot       = more ? FRAG_TOTAL : rem_plus[TOTAL_W-1:0];
    flags_off = {2'b00, more, off_r};
    sum       = SUM_W'(base_r) + SUM_W'(tot) + SUM_W'(flags_off);
    fold1     = 17'(sum[15:0]) + 17'(sum[SUM_W-1:16]);
    fold2     = 17'(fold1[15:0]) + 17'(fold1[16]);
    load      = !busy_r || (adv && !more);
    q_pop     = load && q_valid;
  end

  // Step through fragments, take next request after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r  <= q_data.len;
      off_r  <= '0;
      id_r   <= q_data.id;
      base_r <= q_data.base;
      frag_r <= q_data.frag;
    end else if (adv) begin
      rem_r <= rem_r - FRAG_PAYLOAD;
      off_r <= off_r + FRAG_UNITS;
    end
  end

  // Hold result until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (adv) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      total_r <= tot;
      oid_r   <= id_r;
      mf_r    <= more;
      ooff_r  <= off_r;
      csum_r  <= ~fold2[15:0];
      last_r  <= !more;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_total  = total_r;
  assign out_id     = oid_r;
  assign out_mf     = mf_r;
  assign out_off    = ooff_r;
  assign out_csum   = csum_r;
  assign out_last   = last_r;

`ifndef NO_ASSERTIONS
  a_full_frag_len: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !last_r) |-> (total_r == FRAG_TOTAL))
    else $error("non-final fragment with wrong length");
  a_mf_last: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (mf_r != last_r)) else $error("MF and last disagree");
  a_stay_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && more) |=> busy_r) else $error("request dropped mid-fragmentation");
  a_off_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && more) |=> (off_r == $past(off_r) + FRAG_UNITS))
    else $error("fragment offset did not advance");
`endif

endmodule
`default_nettype wire

// File: tb/sv/ipv4_tx_header_fragmenter_unit_tb.sv
module ipv4_tx_header_fragmenter_unit_tb;
  import ipv4tf_pkg::*;

  // Fragment geometry, derived from the link size
  localparam int unsigned LINK_BYTES = MAX_LINK_PAYLOAD;
  localparam int unsigned IP_HDR_LEN = 20;
  localparam int unsigned FRAG_BYTES = ((LINK_BYTES - IP_HDR_LEN) / 8) * 8;
  localparam int unsigned LEN_CLAMP  = 65515;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_UNUSED = CFG_TIME_TO_LIVE + 1'b1;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned N_DIRECTED = 17;
  localparam int unsigned N_BURST = 8;

  typedef struct packed {
    logic [15:0] payload_len;
    logic [7:0]  proto;
    logic [31:0] dst_ip;
  } ip_req_t;

  typedef struct packed {
    logic [10:0] total_len;
    logic [15:0] ident;
    logic        mf;
    logic [12:0] frag_off;
    logic [15:0] csum;
    logic        is_last;
  } frag_hdr_t;

  // Directed row: typed rows carry the single expected header by hand
  typedef struct packed {
    logic [15:0] payload_len;
    logic [7:0]  proto;
    logic [31:0] dst_ip;
    logic        typed;
    logic [10:0] exp_total;
    logic [15:0] exp_csum;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [55:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [63:0]          out_tdata;
  logic                 out_tlast;

  // Header predictor state
  logic [31:0] model_src_ip;
  logic [7:0]  model_ttl;
  logic [15:0] next_pkt_id;
  frag_hdr_t   pending_hdrs[$];

  logic        out_stall_en;
  int unsigned ready_hold;
  int unsigned quiet_cycles;
  int unsigned n_requests;
  int unsigned n_frag_requests;
  int unsigned n_hdrs_checked;
  int unsigned n_cfg_writes;
  int unsigned n_errors;
  bit          id_wrapped;

  dir_row_t dir_rows [N_DIRECTED];

  ipv4_tx_header_fragmenter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ones' complement sum over the 20-byte header, folded twice
  function automatic logic [15:0] hdr_checksum(logic [10:0] tl, logic [15:0] ident, logic mf,
                                               logic [12:0] off, logic [7:0] proto,
                                               logic [31:0] dst);
    logic [31:0] acc;
    acc = 32'h4500 + 32'(tl) + 32'(ident) + 32'({2'b00, mf, off})
        + 32'({model_ttl, proto})
        + 32'(model_src_ip[31:16]) + 32'(model_src_ip[15:0])
        + 32'(dst[31:16]) + 32'(dst[15:0]);
    acc = 32'(acc[15:0]) + (acc >> 16);
    acc = 32'(acc[15:0]) + (acc >> 16);
    return ~acc[15:0];
  endfunction

  function automatic frag_hdr_t make_hdr(int unsigned tl, logic [15:0] ident, logic mf,
                                         int unsigned off, ip_req_t r, logic is_last);
    frag_hdr_t h;
    h.total_len = 11'(tl);
    h.ident     = ident;
    h.mf        = mf;
    h.frag_off  = 13'(off);
    h.csum      = hdr_checksum(h.total_len, ident, mf, h.frag_off, r.proto, r.dst_ip);
    h.is_last   = is_last;
    return h;
  endfunction

  // Queue the header of every fragment that one request produces
  task automatic predict_fragments(input ip_req_t r);
    int unsigned remaining;
    int unsigned off_units;
    logic [15:0] ident;
    remaining = r.payload_len;
    if (remaining > LEN_CLAMP) remaining = LEN_CLAMP;
    if (remaining + IP_HDR_LEN <= LINK_BYTES) begin
      pending_hdrs.push_back(make_hdr(remaining + IP_HDR_LEN, 16'd0, 1'b0, 0, r, 1'b1));
    end else begin
      ident = next_pkt_id;
      off_units = 0;
      while (remaining > FRAG_BYTES) begin
        pending_hdrs.push_back(make_hdr(FRAG_BYTES + IP_HDR_LEN, ident, 1'b1, off_units, r,
                                        1'b0));
        off_units += FRAG_BYTES / 8;
        remaining -= FRAG_BYTES;
      end
      pending_hdrs.push_back(make_hdr(remaining + IP_HDR_LEN, ident, 1'b0, off_units, r,
                                      1'b1));
      if (next_pkt_id == 16'hffff) id_wrapped = 1'b1;
      next_pkt_id = next_pkt_id + 16'd1;
      n_frag_requests++;
    end
  endtask

  function automatic string hdr_str(frag_hdr_t h);
    return $sformatf("len=%0d id=%h mf=%0d off=%0d csum=%h last=%0d",
                     h.total_len, h.ident, h.mf, h.frag_off, h.csum, h.is_last);
  endfunction

  function automatic ip_req_t rand_request();
    ip_req_t     r;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.payload_len = 16'($urandom_range(0, LINK_BYTES - IP_HDR_LEN));
    end else if (pick < 75) begin
      r.payload_len = 16'($urandom_range(LINK_BYTES - IP_HDR_LEN + 1, 8000));
    end else if (pick < 85) begin
      // land on or just past a fragment boundary
      k = $urandom_range(1, 44);
      r.payload_len = 16'(k * FRAG_BYTES + $urandom_range(0, 1));
    end else if (pick < 93) begin
      r.payload_len = 16'($urandom_range(8001, 65535));
    end else begin
      r.payload_len = 16'($urandom_range(65500, 65535));
    end
    r.proto  = 8'($urandom_range(0, 255));
    r.dst_ip = $urandom();
    return r;
  endfunction

  // Present one request and hold it until the transfer
  task automatic send_request(input ip_req_t r, input bit allow_gaps);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.dst_ip, r.proto, r.payload_len};
    do @(posedge clk); while (!in_tready);
    n_requests++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SOURCE_IP) model_src_ip = val;
    else if (idx == CFG_TIME_TO_LIVE) model_ttl = val[7:0];
    n_cfg_writes++;
  endtask

  // Write both registers plus one unmapped index, then release the channel
  task automatic program_regs(input logic [31:0] src, input logic [7:0] ttl);
    write_reg(CFG_SOURCE_IP, src);
    write_reg(CFG_IDX_FIRST_UNUSED + 8'($urandom_range(0, 255 - CFG_IDX_FIRST_UNUSED)),
              $urandom());
    write_reg(CFG_TIME_TO_LIVE, {24'($urandom()), ttl});
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every header, then let the back end settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_hdrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned n_items, input bit gaps);
    for (int unsigned i = 0; i < n_items; i++) begin
      ip_req_t r;
      r = rand_request();
      send_request(r, gaps && (i % 40) >= 10);
      predict_fragments(r);
    end
    drain();
  endtask

  // Result side: random stall bursts and run lengths
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_stall_en && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(1, 9) - 1;
    end else begin
      out_tready <= 1'b1;
      ready_hold <= out_stall_en ? $urandom_range(0, 12) : 0;
    end
  end

  // Compare each result transfer with the oldest predicted header
  always @(posedge clk) begin
    frag_hdr_t got;
    frag_hdr_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.total_len = out_tdata[10:0];
      got.ident     = out_tdata[26:11];
      got.mf        = out_tdata[27];
      got.frag_off  = out_tdata[40:28];
      got.csum      = out_tdata[56:41];
      got.is_last   = out_tlast;
      n_hdrs_checked++;
      if (pending_hdrs.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected header: %s", hdr_str(got));
      end else begin
        want = pending_hdrs.pop_front();
        if (got !== want || out_tdata[63:57] !== 7'd0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("header mismatch: exp %s / got %s pad=%h",
                     hdr_str(want), hdr_str(got), out_tdata[63:57]);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d headers pending",
               STALL_LIMIT, pending_hdrs.size());
      $display("ipv4_tx_header_fragmenter_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ip_req_t     r;

    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    out_tready   <= 1'b0;
    out_stall_en <= 1'b1;
    ready_hold   = 0;
    quiet_cycles = 0;
    n_requests = 0;
    n_frag_requests = 0;
    n_hdrs_checked = 0;
    n_cfg_writes = 0;
    n_errors = 0;
    id_wrapped = 1'b0;
    model_src_ip = 32'd0;
    model_ttl    = 8'd64;
    next_pkt_id  = 16'd1;

    // len, protocol, destination, typed, total, checksum
    dir_rows = '{
      '{16'd0,     8'h00, 32'h0000_0000, 1'b1, 11'd20,   16'h7aeb},
      '{16'd1480,  8'hff, 32'hffff_ffff, 1'b1, 11'd1500, 16'h7424},
      '{16'd1,     8'h01, 32'h0a00_0001, 1'b0, 11'd0,    16'h0000},
      '{16'd1479,  8'h06, 32'h7f00_0001, 1'b0, 11'd0,    16'h0000},
      '{16'd1481,  8'h11, 32'hc0a8_0102, 1'b0, 11'd0,    16'h0000},
      '{16'd2960,  8'h06, 32'h0000_0000, 1'b0, 11'd0,    16'h0000},
      '{16'd2961,  8'h11, 32'hffff_ffff, 1'b0, 11'd0,    16'h0000},
      '{16'd65515, 8'hff, 32'hffff_ffff, 1'b0, 11'd0,    16'h0000},
      '{16'd65516, 8'h00, 32'h0000_0000, 1'b0, 11'd0,    16'h0000},
      '{16'hffff,  8'h80, 32'h8000_0000, 1'b0, 11'd0,    16'h0000},
      '{16'h8000,  8'h2f, 32'h5555_5555, 1'b0, 11'd0,    16'h0000},
      '{16'd0,     8'hff, 32'hffff_ffff, 1'b0, 11'd0,    16'h0000},
      '{16'h7fff,  8'h55, 32'haaaa_aaaa, 1'b0, 11'd0,    16'h0000},
      '{16'd4440,  8'h01, 32'h0101_0101, 1'b0, 11'd0,    16'h0000},
      '{16'd64, 8'haa, 32'hfedc_ba98, 1'b0, 11'd0, 16'h0000},
      '{16'd1480,  8'h00, 32'h0000_0000, 1'b0, 11'd0,    16'h0000},
      '{16'd3000,  8'h84, 32'h1234_5678, 1'b0, 11'd0,    16'h0000}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset register values
    foreach (dir_rows[i]) begin
      r = '{dir_rows[i].payload_len, dir_rows[i].proto, dir_rows[i].dst_ip};
      send_request(r, 1'b1);
      if (dir_rows[i].typed)
        pending_hdrs.push_back('{dir_rows[i].exp_total, 16'd0, 1'b0, 13'd0,
                                 dir_rows[i].exp_csum, 1'b1});
      else
        predict_fragments(r);
    end
    drain();

    // Random traffic under several register settings
    program_regs(32'hffff_ffff, 8'hff);
    run_random(110, 1'b1);
    program_regs(32'h0000_0000, 8'h00);
    run_random(110, 1'b1);
    program_regs($urandom(), 8'($urandom_range(0, 255)));
    run_random(110, 1'b1);

    // Short burst of back-to-back two-fragment requests, result-side random stalls switched off
    out_stall_en <= 1'b0;
    program_regs($urandom(), 8'd128);
    for (int unsigned i = 0; i < N_BURST; i++) begin
      r = '{16'($urandom_range(FRAG_BYTES + 1, 2 * FRAG_BYTES)), 8'($urandom_range(0, 255)),
            $urandom()};
      send_request(r, 1'b0);
      predict_fragments(r);
    end
    drain();

    // Final stretch with no idling on either side
    program_regs(32'hc0a8_0001, 8'd1);
    run_random(120, 1'b0);

    $display("ran %0d requests (%0d fragmented), checked %0d fragment headers",
             n_requests, n_frag_requests, n_hdrs_checked);
    $display("%0d register writes, id counter wrap %0s, %0d mismatches",
             n_cfg_writes, id_wrapped ? "reached" : "not reached", n_errors);
    if (n_errors == 0 && pending_hdrs.size() == 0) begin
      $display("ipv4_tx_header_fragmenter_unit_tb: PASS");
    end else begin
      $display("ipv4_tx_header_fragmenter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ipv4tf_pkg.sv
hw/rtl/ipv4tf_front.sv
hw/rtl/ipv4tf_queue.sv
hw/rtl/ipv4tf_back.sv
hw/rtl/ipv4_tx_header_fragmenter_unit.sv
tb/sv/ipv4_tx_header_fragmenter_unit_tb.sv
